### rtl/running_mean_stddev_unit_macros.svh
// Assertion macros for the running mean / standard deviation unit.
// Expects clk and rst in scope where used.
`ifndef RUNNING_MEAN_STDDEV_UNIT_MACROS_SVH
`define RUNNING_MEAN_STDDEV_UNIT_MACROS_SVH

// cond implies conseq in the same cycle
`define RMSD_ASSERT_HOLDS(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// cond implies conseq in the next cycle
`define RMSD_ASSERT_AFTER(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

### rtl/rmsd_pkg.sv
// Shared types and constants for the running mean / standard deviation unit.
// No dependencies.
package rmsd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS       = 8;
  localparam int COUNT_BITS      = 17;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 1;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_DATA_W-1:0] GOAL_RESET            = 16'd10;
  localparam logic [CFG_DATA_W-1:0] ABORT_THRESHOLD_RESET = 16'(5 << FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_START   = 2'd1,
    MODE_PREEMPT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_SUCCEEDED = 2'd1,
    ST_ABORTED   = 2'd2,
    ST_PREEMPTED = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_GOAL     = 1'b0,
    REG_ABORT_THRESHOLD = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    JOB_RUNNING = 2'd0,
    JOB_CLOSING = 2'd1,
    JOB_PREEMPT = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQUARE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIVIDE,
    B_SQUARE,
    B_VAR,
    B_ROOT,
    B_DONE
  } back_state_t;

endpackage

### rtl/rmsd_front.sv
// Front end: takes commands and samples, keeps run state and accumulators,
// queues one job per result. Depends on rmsd_pkg.
module rmsd_front #(
  parameter int SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF,
  localparam int SUM_W = SAMPLE_BITS + rmsd_pkg::COUNT_BITS,
  localparam int SQ_W  = 2 * SAMPLE_BITS + rmsd_pkg::COUNT_BITS,
  localparam int JOB_W = 2 + SAMPLE_BITS + SQ_W + SUM_W + rmsd_pkg::COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_mode,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [15:0]            sample_goal,
  output logic                   job_valid,
  input  logic                   job_ready,
  output logic [JOB_W-1:0]       job_data
);

  localparam int CW = rmsd_pkg::COUNT_BITS;

  rmsd_pkg::front_state_t state, state_next;

  logic [1:0]                    mode_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [2*SAMPLE_BITS-1:0]      prod;
  logic                          run_active;
  logic [CW-1:0]                 count_acc;
  logic [SUM_W-1:0]              sum_acc;
  logic [SQ_W-1:0]               square_acc;

  logic signed [2*SAMPLE_BITS-1:0] prod_full;
  logic [CW-1:0]                   count_inc;
  logic [SUM_W-1:0]                sum_new;
  logic [SQ_W-1:0]                 sq_new;
  logic                            closing;
  logic                            commit;
  logic [1:0]                      kind;

  assign prod_full = sample_r * sample_r;
  assign count_inc = count_acc + CW'(1);
  assign sum_new   = sum_acc + SUM_W'(sample_r);
  assign sq_new    = square_acc + SQ_W'(prod);
  assign closing   = count_inc > {1'b0, sample_goal};
  assign kind      = closing ? rmsd_pkg::JOB_CLOSING : rmsd_pkg::JOB_RUNNING;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_valid  = 1'b0;
    job_data   = {kind, sample_r, sq_new, sum_new, count_inc};
    commit     = 1'b0;
    case (state)
      rmsd_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = rmsd_pkg::F_SQUARE;
      end
      rmsd_pkg::F_SQUARE: begin
        state_next = rmsd_pkg::F_UPDATE;
      end
      rmsd_pkg::F_UPDATE: begin
        case (mode_r)
          rmsd_pkg::MODE_SAMPLE: begin
            job_valid = run_active;
            commit    = run_active && job_ready;
            if (!run_active || job_ready) state_next = rmsd_pkg::F_IDLE;
          end
          rmsd_pkg::MODE_START: begin
            commit     = 1'b1;
            state_next = rmsd_pkg::F_IDLE;
          end
          rmsd_pkg::MODE_PREEMPT: begin
            job_valid = run_active;
            job_data  = {rmsd_pkg::JOB_PREEMPT, {SAMPLE_BITS{1'b0}}, square_acc, sum_acc,
                         count_acc};
            commit    = run_active && job_ready;
            if (!run_active || job_ready) state_next = rmsd_pkg::F_IDLE;
          end
          default: begin
            state_next = rmsd_pkg::F_IDLE;
          end
        endcase
      end
      default: begin
        state_next = rmsd_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmsd_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      count_acc  <= '0;
      sum_acc    <= '0;
      square_acc <= '0;
    end else if (commit) begin
      case (mode_r)
        rmsd_pkg::MODE_SAMPLE: begin
          count_acc  <= count_inc;
          sum_acc    <= sum_new;
          square_acc <= sq_new;
          if (closing) run_active <= 1'b0;
        end
        rmsd_pkg::MODE_START: begin
          run_active <= 1'b1;
          count_acc  <= '0;
          sum_acc    <= '0;
          square_acc <= '0;
        end
        rmsd_pkg::MODE_PREEMPT: begin
          run_active <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      sample_r <= in_sample;
    end
    if (state == rmsd_pkg::F_SQUARE) prod <= $unsigned(prod_full);
  end

endmodule

### rtl/rmsd_fifo.sv
// Small job queue between front and back end.
// Depends on nothing; depth and width come from the instantiating module.
module rmsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push, do_pop;

  assign push_ready = level != LVL_W'(DEPTH);
  assign pop_valid  = level != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) level <= level + LVL_W'(1);
      else if (do_pop && !do_push) level <= level - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

### rtl/rmsd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module rmsd_div #(
  parameter int NUM_BITS = 33,
  parameter int DEN_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                busy,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] work;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [CNT_W-1:0]    cnt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  assign trial    = {rem, work[NUM_BITS-1]};
  assign diff     = trial - {1'b0, den};
  assign fits     = trial >= {1'b0, den};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  // work shifts the dividend out at the top and the quotient in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      den  <= divisor;
      cnt  <= CNT_W'(NUM_BITS);
    end else if (busy) begin
      rem  <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      work <= {work[NUM_BITS-2:0], fits};
      cnt  <= cnt - CNT_W'(1);
    end
  end

endmodule

### rtl/rmsd_back.sv
// Back end: per job, divides for mean and mean square, forms the variance,
// takes its square root and holds the result word. Depends on rmsd_pkg, rmsd_div.
module rmsd_back #(
  parameter int SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF,
  localparam int SUM_W = SAMPLE_BITS + rmsd_pkg::COUNT_BITS,
  localparam int SQ_W  = 2 * SAMPLE_BITS + rmsd_pkg::COUNT_BITS,
  localparam int JOB_W = 2 + SAMPLE_BITS + SQ_W + SUM_W + rmsd_pkg::COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  logic [JOB_W-1:0]               job_data,
  input  logic [15:0]                    abort_threshold,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rmsd_pkg::COUNT_BITS-1:0] out_count,
  output logic [SAMPLE_BITS-1:0]         out_echo,
  output logic [SAMPLE_BITS-1:0]         out_mean,
  output logic [SAMPLE_BITS-1:0]         out_sd,
  output logic [1:0]                     out_status
);

  localparam int CW    = rmsd_pkg::COUNT_BITS;
  localparam int S     = SAMPLE_BITS;
  localparam int RC_W  = $clog2(S + 1);
  localparam int CMP_W = (S > 16) ? S : 16;

  rmsd_pkg::back_state_t state, state_next;

  // job fields
  logic [CW-1:0]    count_j;
  logic [SUM_W-1:0] sum_j;
  logic [SUM_W-1:0] sum_abs;
  logic [SQ_W-1:0]  sq_j;
  logic [S-1:0]     echo_j;
  logic [1:0]       kind_j;

  assign count_j = job_data[CW-1:0];
  assign sum_j   = job_data[CW +: SUM_W];
  assign sq_j    = job_data[CW + SUM_W +: SQ_W];
  assign echo_j  = job_data[CW + SUM_W + SQ_W +: S];
  assign kind_j  = job_data[JOB_W-1 -: 2];
  assign sum_abs = sum_j[SUM_W-1] ? -sum_j : sum_j;

  logic             div_start;
  logic             mean_busy, sq_busy;
  logic [SUM_W-1:0] mean_quo;
  logic [SQ_W-1:0]  sq_quo;

  rmsd_div #(.NUM_BITS(SUM_W), .DEN_BITS(CW)) u_div_mean (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_abs),
    .divisor  (count_j),
    .busy     (mean_busy),
    .quotient (mean_quo)
  );

  rmsd_div #(.NUM_BITS(SQ_W), .DEN_BITS(CW)) u_div_sq (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sq_j),
    .divisor  (count_j),
    .busy     (sq_busy),
    .quotient (sq_quo)
  );

  logic [1:0]          kind;
  logic [S-1:0]        echo;
  logic [CW-1:0]       count_r;
  logic                sum_neg;
  logic signed [S-1:0] mean_r;
  logic [2*S-1:0]      msq;
  logic [2*S-1:0]      q2;
  logic [2*S-1:0]      rad;
  logic [S:0]          rem;
  logic [S-1:0]        root;
  logic [RC_W-1:0]     cnt;

  logic signed [2*S-1:0] msq_full;
  logic signed [2*S:0]   diff;
  logic [2*S:0]          diff_abs;
  logic [S+2:0]          rem_sh;
  logic [S+2:0]          trial;
  logic [S+2:0]          rem_sub;
  logic                  fits;
  logic [S-1:0]          mean_mag;
  logic signed [15:0]    thr_s;
  logic signed [CMP_W-1:0] mean_cmp, thr_cmp;
  logic [1:0]            status;
  logic                  load_out;

  assign msq_full = mean_r * mean_r;
  assign diff     = $signed({1'b0, q2}) - $signed({1'b0, msq});
  assign diff_abs = diff[2*S] ? -diff : diff;
  assign rem_sh   = {rem, rad[2*S-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign rem_sub  = rem_sh - trial;
  assign fits     = rem_sh >= trial;
  assign mean_mag = mean_quo[S-1:0];
  assign thr_s    = abort_threshold;
  assign mean_cmp = CMP_W'(mean_r);
  assign thr_cmp  = CMP_W'(thr_s);

  always_comb begin
    case (kind)
      rmsd_pkg::JOB_RUNNING: status = rmsd_pkg::ST_RUNNING;
      rmsd_pkg::JOB_CLOSING:
        status = (mean_cmp > thr_cmp) ? rmsd_pkg::ST_ABORTED : rmsd_pkg::ST_SUCCEEDED;
      default:               status = rmsd_pkg::ST_PREEMPTED;
    endcase
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      rmsd_pkg::B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          // an empty run (preempt right after start) skips the math
          if (count_j == '0) begin
            state_next = rmsd_pkg::B_DONE;
          end else begin
            div_start  = 1'b1;
            state_next = rmsd_pkg::B_DIVIDE;
          end
        end
      end
      rmsd_pkg::B_DIVIDE: begin
        if (!mean_busy && !sq_busy) state_next = rmsd_pkg::B_SQUARE;
      end
      rmsd_pkg::B_SQUARE: begin
        state_next = rmsd_pkg::B_VAR;
      end
      rmsd_pkg::B_VAR: begin
        state_next = rmsd_pkg::B_ROOT;
      end
      rmsd_pkg::B_ROOT: begin
        if (cnt == RC_W'(1)) state_next = rmsd_pkg::B_DONE;
      end
      rmsd_pkg::B_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = rmsd_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = rmsd_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmsd_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rmsd_pkg::B_IDLE: begin
        kind    <= kind_j;
        echo    <= echo_j;
        count_r <= count_j;
        sum_neg <= sum_j[SUM_W-1];
        mean_r  <= '0;
        root    <= '0;
      end
      rmsd_pkg::B_DIVIDE: begin
        mean_r <= sum_neg ? -mean_mag : mean_mag;
        q2     <= sq_quo[2*S-1:0];
      end
      rmsd_pkg::B_SQUARE: begin
        msq <= $unsigned(msq_full);
      end
      rmsd_pkg::B_VAR: begin
        rad  <= diff_abs[2*S-1:0];
        rem  <= '0;
        root <= '0;
        cnt  <= RC_W'(S);
      end
      rmsd_pkg::B_ROOT: begin
        // two radicand bits per step, one root bit out
        rem  <= fits ? rem_sub[S:0] : rem_sh[S:0];
        root <= {root[S-2:0], fits};
        rad  <= {rad[2*S-3:0], 2'b00};
        cnt  <= cnt - RC_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_count  <= count_r;
      out_echo   <= echo;
      out_mean   <= mean_r;
      out_sd     <= root;
      out_status <= status;
    end
  end

endmodule

### rtl/running_mean_stddev_unit.sv
// The result rate is set by the back end's bit-serial divide and square root; the
// front end takes new samples until the queue is full, while earlier jobs wait in
// the two-entry queue or are in the back end. Start words queue no job and give no result.
// Reset (rst, synchronous) clears run state, accumulators, queue and result valid and
// restores sample_goal 10 and abort_threshold 5.0; no clearing pass.
`include "running_mean_stddev_unit_macros.svh"

module running_mean_stddev_unit #(
  parameter int SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF,
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W       = rmsd_pkg::COUNT_BITS + 3 * SAMPLE_BITS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata,  // sample_value
  input  logic [1:0]                        s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sample_count, sample_echo, mean_value, std_dev
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,  // run_status
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rmsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + rmsd_pkg::COUNT_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS + rmsd_pkg::COUNT_BITS;
  localparam int JOB_W = 2 + SAMPLE_BITS + SQ_W + SUM_W + rmsd_pkg::COUNT_BITS;

  logic [rmsd_pkg::CFG_DATA_W-1:0] sample_goal;
  logic [rmsd_pkg::CFG_DATA_W-1:0] abort_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_goal     <= rmsd_pkg::GOAL_RESET;
      abort_threshold <= rmsd_pkg::ABORT_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rmsd_pkg::REG_SAMPLE_GOAL:     sample_goal     <= cfg_data;
        rmsd_pkg::REG_ABORT_THRESHOLD: abort_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic             q_push_valid, q_push_ready;
  logic [JOB_W-1:0] q_push_data;
  logic             q_pop_valid, q_pop_ready;
  logic [JOB_W-1:0] q_pop_data;

  rmsd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_mode     (s_axis_tuser),
    .in_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .sample_goal (sample_goal),
    .job_valid   (q_push_valid),
    .job_ready   (q_push_ready),
    .job_data    (q_push_data)
  );

  rmsd_fifo #(.WIDTH(JOB_W), .DEPTH(rmsd_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  logic [rmsd_pkg::COUNT_BITS-1:0] out_count;
  logic [SAMPLE_BITS-1:0]          out_echo;
  logic [SAMPLE_BITS-1:0]          out_mean;
  logic [SAMPLE_BITS-1:0]          out_sd;

  rmsd_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (q_pop_valid),
    .job_ready       (q_pop_ready),
    .job_data        (q_pop_data),
    .abort_threshold (abort_threshold),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_count       (out_count),
    .out_echo        (out_echo),
    .out_mean        (out_mean),
    .out_sd          (out_sd),
    .out_status      (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'({out_sd, out_mean, out_echo, out_count});

  logic out_preempt, out_in_run;

  assign out_preempt = m_axis_tvalid && (m_axis_tuser == rmsd_pkg::ST_PREEMPTED);
  assign out_in_run  = m_axis_tvalid && (m_axis_tuser != rmsd_pkg::ST_PREEMPTED);

  `RMSD_ASSERT_HOLDS(a_preempt_echo_zero, out_preempt, out_echo == '0, "preempt word with sample")
  `RMSD_ASSERT_HOLDS(a_sample_count_nonzero, out_in_run, out_count != '0, "sample word, zero count")
  `RMSD_ASSERT_AFTER(a_back_one_job, q_pop_valid && q_pop_ready, !q_pop_ready, "second job while busy")

endmodule

### bench/tb_running_mean_stddev_unit.sv
// Testbench for running_mean_stddev_unit: a directed table, then random runs,
// each result word checked against a table entry or a behavioral model of the running statistics.
// Depends on rmsd_pkg and the running_mean_stddev_unit RTL.
module tb_running_mean_stddev_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 4;
  localparam int QUIET_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 1500;
  localparam int RANDOM_ITEMS = 750;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  typedef struct {
    logic [16:0]       count;
    logic [15:0]       echo;
    logic [15:0]       mean;
    logic [15:0]       sd;
    rmsd_pkg::status_t status;
  } stats_word_t;

  typedef struct {
    bit          cfg;
    logic [1:0]  mode;
    logic [15:0] value;   // goal on cfg rows
    logic [15:0] thr;
    bit          typed;
    stats_word_t want;
  } plan_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [15:0]                      s_axis_tdata = '0;   // sample_value
  logic [1:0]                       s_axis_tuser = '0;   // mode
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [71:0]                      m_axis_tdata;  // sample_count, sample_echo, mean_value, std_dev
  logic [1:0]                       m_axis_tuser;        // run_status
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rmsd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rmsd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  running_mean_stddev_unit dut (.*);

  always #(CLK_HALF) clk = ~clk;

  // model state
  bit                 run_open = 1'b0;
  int unsigned        run_count = 0;
  longint             run_sum = 0;
  longint             run_sqsum = 0;
  logic [15:0]        goal_reg = rmsd_pkg::GOAL_RESET;
  logic signed [15:0] thr_reg = rmsd_pkg::ABORT_THRESHOLD_RESET;

  stats_word_t stats_due[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          hold_requests = 0;
  int unsigned burst_left = 0;

  function automatic longint floor_root(longint v);
    longint root = 0;
    longint probe = longint'(1) << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic stats_word_t snapshot_stats(longint echo, rmsd_pkg::status_t st);
    stats_word_t w;
    longint m = 0;
    longint v = 0;
    if (run_count != 0) begin
      m = run_sum / longint'(run_count);
      v = run_sqsum / longint'(run_count) - m * m;
      if (v < 0) v = -v;
    end
    w.count  = run_count[16:0];
    w.echo   = echo[15:0];
    w.mean   = m[15:0];
    w.sd     = 16'(floor_root(v));
    w.status = st;
    return w;
  endfunction

  // Applies one accepted word to the model; returns 1 when it yields a result.
  function automatic bit advance_stats(logic [1:0] mode, logic [15:0] value,
                                       output stats_word_t w);
    longint s;
    s = longint'($signed(value));
    case (mode)
      rmsd_pkg::MODE_START: begin
        run_open  = 1'b1;
        run_count = 0;
        run_sum   = 0;
        run_sqsum = 0;
        return 1'b0;
      end
      rmsd_pkg::MODE_PREEMPT: begin
        if (!run_open) return 1'b0;
        run_open = 1'b0;
        w = snapshot_stats(0, rmsd_pkg::ST_PREEMPTED);
        return 1'b1;
      end
      rmsd_pkg::MODE_SAMPLE: begin
        if (!run_open) return 1'b0;
        run_count++;
        run_sum   += s;
        run_sqsum += s * s;
        w = snapshot_stats(s, rmsd_pkg::ST_RUNNING);
        if (run_count > goal_reg) begin
          run_open = 1'b0;
          w.status = ($signed(w.mean) > thr_reg) ? rmsd_pkg::ST_ABORTED
                                                 : rmsd_pkg::ST_SUCCEEDED;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void note_mismatch(string what, stats_word_t e, stats_word_t g);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp cnt=%0d echo=%h mean=%h sd=%h st=%s / got cnt=%0d echo=%h %s",
               $time, what, e.count, e.echo, e.mean, e.sd, e.status.name(),
               g.count, g.echo,
               $sformatf("mean=%h sd=%h st=%s", g.mean, g.sd, g.status.name()));
  endfunction

  function automatic logic [15:0] pick_sample(logic [15:0] center);
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
      default: return center + 16'($urandom_range(0, 1023)) - 16'd512;
    endcase
  endfunction

  function automatic plan_row_t word_row(logic [1:0] mode, logic [15:0] value);
    plan_row_t r;
    r.cfg   = 1'b0;
    r.mode  = mode;
    r.value = value;
    r.thr   = '0;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [1:0] mode, logic [15:0] value,
                                          logic [16:0] count, logic [15:0] echo,
                                          logic [15:0] mean, rmsd_pkg::status_t st);
    plan_row_t r;
    r = word_row(mode, value);
    r.typed       = 1'b1;
    r.want.count  = count;
    r.want.echo   = echo;
    r.want.mean   = mean;
    r.want.sd     = '0;
    r.want.status = st;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [15:0] goal, logic [15:0] thr);
    plan_row_t r;
    r = word_row(rmsd_pkg::MODE_SAMPLE, goal);
    r.cfg = 1'b1;
    r.thr = thr;
    return r;
  endfunction

  // Offers one word in bursts with random gaps; predicts once it is taken.
  task automatic send_word(input logic [1:0] mode, input logic [15:0] value, input bit typed,
                           input stats_word_t want, output bit counted);
    int          gap;
    bit          has_result;
    stats_word_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 120 : 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    has_result = advance_stats(mode, value, w);
    if (has_result) stats_due.push_back(typed ? want : w);
    counted = has_result || (mode == rmsd_pkg::MODE_START);
  endtask

  // Sender pauses until every result is back, then lets the back end settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] goal, input logic [15:0] thr);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= rmsd_pkg::REG_SAMPLE_GOAL;
    cfg_data  <= goal;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    goal_reg = goal;
    cfg_index <= rmsd_pkg::REG_ABORT_THRESHOLD;
    cfg_data  <= thr;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    thr_reg = thr;
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall density changes from span to span, plus long holds on request.
  initial begin : result_sink
    int pct;
    int span;
    int hold_left;
    int holds_served;
    pct          = 100;
    span         = 0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (span == 0) begin
        span = $urandom_range(50, 400);
        case ($urandom_range(0, 2))
          0: pct = 100;
          1: pct = 60;
          default: pct = 20;
        endcase
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    stats_word_t got;
    stats_word_t exp_w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.count  = m_axis_tdata[16:0];
      got.echo   = m_axis_tdata[32:17];
      got.mean   = m_axis_tdata[48:33];
      got.sd     = m_axis_tdata[64:49];
      got.status = rmsd_pkg::status_t'(m_axis_tuser);
      if (stats_due.size() == 0) begin
        note_mismatch("result word with none pending", got, got);
      end else begin
        exp_w = stats_due.pop_front();
        if (got.count !== exp_w.count || got.echo !== exp_w.echo ||
            got.mean !== exp_w.mean || got.sd !== exp_w.sd || got.status !== exp_w.status)
          note_mismatch("result word mismatch", exp_w, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("running_mean_stddev_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    stats_word_t none;
    bit          counted;
    logic [15:0] center;
    logic [15:0] goal;
    logic [15:0] thr;
    int          items;
    int          n;
    int          ending;

    // no run open: sample and preempt are dropped
    plan.push_back(word_row(rmsd_pkg::MODE_SAMPLE, 16'h1234));
    plan.push_back(word_row(rmsd_pkg::MODE_PREEMPT, 16'h0000));
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'h0000));
    plan.push_back(known_row(rmsd_pkg::MODE_PREEMPT, 16'h0000, 17'd0, 16'h0000, 16'h0000,
                             rmsd_pkg::ST_PREEMPTED));
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'h0000));
    plan.push_back(known_row(rmsd_pkg::MODE_SAMPLE, 16'h7FFF, 17'd1, 16'h7FFF, 16'h7FFF,
                             rmsd_pkg::ST_RUNNING));
    // restart while open
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'hFFFF));
    plan.push_back(known_row(rmsd_pkg::MODE_SAMPLE, 16'h8000, 17'd1, 16'h8000, 16'h8000,
                             rmsd_pkg::ST_RUNNING));
    plan.push_back(word_row(rmsd_pkg::MODE_SAMPLE, 16'h7FFF));
    plan.push_back(word_row(MODE_IGNORED, 16'hFFFF));
    plan.push_back(word_row(rmsd_pkg::MODE_SAMPLE, 16'h0000));
    plan.push_back(word_row(rmsd_pkg::MODE_PREEMPT, 16'h5A5A));
    // single-sample runs at the threshold extremes
    plan.push_back(cfg_row(16'd0, 16'h7FFF));
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'h0000));
    plan.push_back(known_row(rmsd_pkg::MODE_SAMPLE, 16'h7FFF, 17'd1, 16'h7FFF, 16'h7FFF,
                             rmsd_pkg::ST_SUCCEEDED));
    plan.push_back(word_row(rmsd_pkg::MODE_SAMPLE, 16'h1111));
    plan.push_back(cfg_row(16'd0, 16'h8000));
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'h0000));
    plan.push_back(known_row(rmsd_pkg::MODE_SAMPLE, 16'h8000, 17'd1, 16'h8000, 16'h8000,
                             rmsd_pkg::ST_SUCCEEDED));
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'h0000));
    plan.push_back(known_row(rmsd_pkg::MODE_SAMPLE, 16'h8001, 17'd1, 16'h8001, 16'h8001,
                             rmsd_pkg::ST_ABORTED));
    // mean equal to the threshold does not abort, one LSB above does
    plan.push_back(cfg_row(16'd0, rmsd_pkg::ABORT_THRESHOLD_RESET));
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'h0000));
    plan.push_back(known_row(rmsd_pkg::MODE_SAMPLE, 16'h0500, 17'd1, 16'h0500, 16'h0500,
                             rmsd_pkg::ST_SUCCEEDED));
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'h0000));
    plan.push_back(known_row(rmsd_pkg::MODE_SAMPLE, 16'h0501, 17'd1, 16'h0501, 16'h0501,
                             rmsd_pkg::ST_ABORTED));
    // goal lowered mid-run: next sample closes it
    plan.push_back(cfg_row(16'hFFFF, rmsd_pkg::ABORT_THRESHOLD_RESET));
    plan.push_back(word_row(rmsd_pkg::MODE_START, 16'h0000));
    plan.push_back(word_row(rmsd_pkg::MODE_SAMPLE, 16'h0100));
    plan.push_back(word_row(rmsd_pkg::MODE_SAMPLE, 16'hFF00));
    plan.push_back(word_row(rmsd_pkg::MODE_SAMPLE, 16'h2AAA));
    plan.push_back(cfg_row(16'd1, rmsd_pkg::ABORT_THRESHOLD_RESET));
    plan.push_back(word_row(rmsd_pkg::MODE_SAMPLE, 16'h5555));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        set_regs(plan[i].value, plan[i].thr);
      end else begin
        send_word(plan[i].mode, plan[i].value, plan[i].typed, plan[i].want, counted);
      end
    end

    // long run while the sink holds off, so the input backs up
    items = 0;
    set_regs(16'd30, 16'h0200);
    hold_requests++;
    center = 16'h0180;
    send_word(rmsd_pkg::MODE_START, 16'h0000, 1'b0, none, counted);
    items += counted;
    repeat (31) begin
      send_word(rmsd_pkg::MODE_SAMPLE, pick_sample(center), 1'b0, none, counted);
      items += counted;
    end

    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 9))
          0: goal = 16'hFFFF;
          1: goal = 16'd0;
          default: goal = 16'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 7))
          0: thr = 16'h8000;
          1: thr = 16'h7FFF;
          default: thr = 16'($urandom_range(0, 4095) - 2048);
        endcase
        set_regs(goal, thr);
      end
      center = ($urandom_range(0, 7) == 0) ? 16'($urandom)
             : 16'($urandom_range(0, 4095) - 2048);
      if ($urandom_range(0, 9) == 0) begin
        // noise word: any mode, any value
        send_word(2'($urandom), 16'($urandom), 1'b0, none, counted);
        items += counted;
      end else begin
        send_word(rmsd_pkg::MODE_START, 16'($urandom), 1'b0, none, counted);
        items += counted;
        n = (goal_reg > 40) ? $urandom_range(0, 20) : goal_reg + 1;
        ending = $urandom_range(0, 5);
        if (goal_reg <= 40 && ending == 0) n = $urandom_range(0, goal_reg);
        for (int k = 0; k < n; k++) begin
          send_word(rmsd_pkg::MODE_SAMPLE, pick_sample(center), 1'b0, none, counted);
          items += counted;
        end
        if (run_open && ending != 1) begin
          send_word(rmsd_pkg::MODE_PREEMPT, 16'($urandom), 1'b0, none, counted);
          items += counted;
        end else if (!run_open && ending == 2) begin
          // sample after the run closed is dropped
          send_word(rmsd_pkg::MODE_SAMPLE, 16'($urandom), 1'b0, none, counted);
        end
      end
    end

    drain_results();
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("running_mean_stddev_unit test passed");
    end else begin
      $display("running_mean_stddev_unit test failed");
    end
    $finish;
  end

endmodule
